// ----- hdl/dwc_pkg.sv -----
// dwc_pkg: shared types and codes of the deque with cursor
// command and result transaction structs, internal pipeline structs, command and status codes
// no dependencies
package dwc_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_BACK   = 3'd0;
  localparam logic [2:0] CMD_POP_FRONT   = 3'd1;
  localparam logic [2:0] CMD_POP_BACK    = 3'd2;
  localparam logic [2:0] CMD_CUR_NEXT    = 3'd3;
  localparam logic [2:0] CMD_CUR_PREV    = 3'd4;
  localparam logic [2:0] CMD_CUR_FRONT   = 3'd5;
  localparam logic [2:0] CMD_CUR_BACK    = 3'd6;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_AT_END = 2'd3;

  // input transaction
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_in;
  } cmd_t;

  // result transaction
  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [7:0] front_item;
    logic [7:0] back_item;
    logic [4:0] item_count;
    logic [7:0] cursor_item;
  } result_t;

  // cached bytes at the front, back and cursor positions
  typedef struct packed {
    logic [7:0] front;
    logic [7:0] back;
    logic [7:0] cursor;
  } bytes_t;

  // which cached bytes take the ram read data
  typedef struct packed {
    logic front;
    logic back;
    logic cursor;
  } fix_t;

  // command result waiting for its ram read
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic       data_mem;
    fix_t       fix;
    bytes_t     bytes;
    logic [4:0] item_count;
  } pend_t;

endpackage

// ----- hdl/deque_with_cursor_core.sv -----
// deque_with_cursor_core: top level of the bounded byte deque with cursor
// holds the pipeline registers, pointer state, byte caches and the ring ram
// depends on dwc_pkg, dwc_step, dwc_ram
//
// Bounded double-ended byte queue of DEPTH entries in a ring buffer, with a
// browsing cursor. One command is accepted per cycle, sustained while the
// result side does not stall, and each gives one result, passing the input
// register, the ram read stage, then the result register. The rate is set by
// the single registered read port of the ring ram: every command needs at most
// one ram read, and the front, back and cursor bytes are cached in registers,
// with the read data bypassed into the next command. The ram needs no clearing
// after reset. item_count reports the low five bits of the count.
module deque_with_cursor_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dwc_pkg::cmd_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dwc_pkg::result_t  out_data_o
);

  import dwc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             a_v_q;
  cmd_t             a_cmd_q;
  logic             b_v_q;
  pend_t            b_q;
  logic             out_v_q;
  result_t          out_q;
  logic [IDX_W-1:0] head_q;
  logic [IDX_W-1:0] head_d;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic [IDX_W-1:0] off_q;
  logic [IDX_W-1:0] off_d;
  bytes_t           bytes_q;
  bytes_t           bytes_m;
  bytes_t           bytes_cur;
  logic             adv_out;
  logic             adv_b;
  logic             in_fire;
  logic             a_fire;
  logic             b_fire;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  pend_t            pend;
  result_t          res;

  // stage advance
  assign adv_out    = !out_v_q || out_ready_i;
  assign adv_b      = !b_v_q || adv_out;
  assign in_ready_o = !a_v_q || adv_b;
  assign in_fire    = in_valid_i && in_ready_o;
  assign a_fire     = a_v_q && adv_b;
  assign b_fire     = b_v_q && adv_out;

  // merge pending ram read into the cached bytes
  always_comb begin
    bytes_m        = b_q.bytes;
    if (b_q.fix.front) begin
      bytes_m.front = rd_data;
    end
    if (b_q.fix.back) begin
      bytes_m.back = rd_data;
    end
    if (b_q.fix.cursor) begin
      bytes_m.cursor = rd_data;
    end
  end

  assign bytes_cur = b_v_q ? bytes_m : bytes_q;

  // result assembly
  always_comb begin
    res.data_out    = b_q.data_mem ? rd_data : b_q.data_out;
    res.status      = b_q.status;
    res.front_item  = bytes_m.front;
    res.back_item   = bytes_m.back;
    res.item_count  = b_q.item_count;
    res.cursor_item = bytes_m.cursor;
  end

  dwc_step #(
    .DEPTH (DEPTH)
  ) u_step (
    .cmd_i     (a_cmd_q),
    .head_i    (head_q),
    .cnt_i     (cnt_q),
    .off_i     (off_q),
    .bytes_i   (bytes_cur),
    .head_o    (head_d),
    .cnt_o     (cnt_d),
    .off_o     (off_d),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .pend_o    (pend)
  );

  dwc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && a_fire),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en && a_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // valid flags and pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      head_q  <= '0;
      cnt_q   <= '0;
      off_q   <= '0;
      bytes_q <= '0;
    end else begin
      if (in_fire) begin
        a_v_q <= 1'b1;
      end else if (a_fire) begin
        a_v_q <= 1'b0;
      end
      if (a_fire) begin
        b_v_q  <= 1'b1;
        head_q <= head_d;
        cnt_q  <= cnt_d;
        off_q  <= off_d;
      end else if (b_fire) begin
        b_v_q <= 1'b0;
      end
      if (b_fire) begin
        out_v_q <= 1'b1;
        bytes_q <= bytes_m;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_cmd_q <= in_data_i;
    end
    if (a_fire) begin
      b_q <= pend;
    end
    if (b_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // cursor stays inside the stored entries, at zero when empty
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) ? (off_q == '0) : (CNT_W'(off_q) < cnt_q))
    else $error("cursor offset out of range");

  // a command either writes or reads the ram, never both
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_v_q && wr_en && rd_en))
    else $error("ram write and read in one command");

  // settled empty queue caches zero bytes
  a_empty_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && !b_v_q) |-> (bytes_q == '0))
    else $error("cached bytes nonzero on empty queue");

  // ram read data is held while the pending result stalls
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_v_q && !adv_out) |=> $stable(rd_data))
    else $error("ram read data changed under a stalled result");

endmodule

// ----- hdl/dwc_ram.sv -----
// dwc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dwc_step.sv -----
// dwc_step: next-state logic of one command of the deque with cursor
// computes pointers, the ram request and the pending result
// depends on dwc_pkg
module dwc_step #(
  parameter int DEPTH = 16
) (
  input  dwc_pkg::cmd_t                    cmd_i,
  input  logic [$clog2(DEPTH)-1:0]         head_i,
  input  logic [$clog2(DEPTH+1)-1:0]       cnt_i,
  input  logic [$clog2(DEPTH)-1:0]         off_i,
  input  dwc_pkg::bytes_t                  bytes_i,
  output logic [$clog2(DEPTH)-1:0]         head_o,
  output logic [$clog2(DEPTH+1)-1:0]       cnt_o,
  output logic [$clog2(DEPTH)-1:0]         off_o,
  output logic                             wr_en_o,
  output logic [$clog2(DEPTH)-1:0]         wr_addr_o,
  output logic [7:0]                       wr_data_o,
  output logic                             rd_en_o,
  output logic [$clog2(DEPTH)-1:0]         rd_addr_o,
  output dwc_pkg::pend_t                   pend_o
);

  import dwc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0] DEPTH_S = (IDX_W + 1)'(DEPTH);

  // ring slot of an offset from the front, one compare and subtract
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, ofs};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IDX_W-1:0];
  endfunction

  logic             empty;
  logic             full;
  logic             last;
  logic [CNT_W-1:0] cm1;
  logic [CNT_W-1:0] cm2;
  logic [CNT_W-1:0] off_c;
  logic [IDX_W-1:0] slot_push;
  logic [IDX_W-1:0] slot_sec;
  logic [IDX_W-1:0] slot_bk2;
  logic [IDX_W-1:0] slot_nxt;
  logic [IDX_W-1:0] slot_prv;

  assign empty     = (cnt_i == '0);
  assign full      = (cnt_i == CNT_W'(DEPTH));
  assign last      = (cnt_i == CNT_W'(1));
  assign cm1       = cnt_i - CNT_W'(1);
  assign cm2       = cnt_i - CNT_W'(2);
  assign off_c     = CNT_W'(off_i);
  assign slot_push = slot_of(head_i, cnt_i[IDX_W-1:0]);
  assign slot_sec  = slot_of(head_i, IDX_W'(1));
  assign slot_bk2  = slot_of(head_i, cm2[IDX_W-1:0]);
  assign slot_nxt  = slot_of(head_i, off_i + IDX_W'(1));
  assign slot_prv  = slot_of(head_i, off_i - IDX_W'(1));

  // command decode and state update
  always_comb begin
    head_o          = head_i;
    cnt_o           = cnt_i;
    off_o           = off_i;
    wr_en_o         = 1'b0;
    wr_addr_o       = slot_push;
    wr_data_o       = cmd_i.data_in;
    rd_en_o         = 1'b0;
    rd_addr_o       = slot_sec;
    pend_o.status   = ST_DONE;
    pend_o.data_out = '0;
    pend_o.data_mem = 1'b0;
    pend_o.fix      = '0;
    pend_o.bytes    = bytes_i;
    unique case (cmd_i.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          pend_o.status = ST_FULL;
        end else begin
          wr_en_o           = 1'b1;
          cnt_o             = cnt_i + CNT_W'(1);
          pend_o.bytes.back = cmd_i.data_in;
          if (empty) begin
            off_o               = '0;
            pend_o.bytes.front  = cmd_i.data_in;
            pend_o.bytes.cursor = cmd_i.data_in;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else begin
          pend_o.data_out = bytes_i.front;
          head_o          = slot_sec;
          cnt_o           = cm1;
          off_o           = (off_i == '0) ? '0 : off_i - IDX_W'(1);
          if (last) begin
            off_o        = '0;
            pend_o.bytes = '0;
          end else begin
            rd_en_o          = 1'b1;
            rd_addr_o        = slot_sec;
            pend_o.fix.front = 1'b1;
            if (off_i == '0) begin
              pend_o.fix.cursor = 1'b1;
            end
          end
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else begin
          pend_o.data_out = bytes_i.back;
          cnt_o           = cm1;
          if (last) begin
            off_o        = '0;
            pend_o.bytes = '0;
          end else begin
            rd_en_o         = 1'b1;
            rd_addr_o       = slot_bk2;
            pend_o.fix.back = 1'b1;
            // cursor on the popped entry moves to the new back
            if (off_c >= cm1) begin
              off_o             = cm2[IDX_W-1:0];
              pend_o.fix.cursor = 1'b1;
            end
          end
        end
      end
      CMD_CUR_NEXT: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else if (off_c < cm1) begin
          off_o             = off_i + IDX_W'(1);
          rd_en_o           = 1'b1;
          rd_addr_o         = slot_nxt;
          pend_o.data_mem   = 1'b1;
          pend_o.fix.cursor = 1'b1;
        end else begin
          pend_o.status = ST_AT_END;
        end
      end
      CMD_CUR_PREV: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else if (off_i != '0) begin
          off_o             = off_i - IDX_W'(1);
          rd_en_o           = 1'b1;
          rd_addr_o         = slot_prv;
          pend_o.data_mem   = 1'b1;
          pend_o.fix.cursor = 1'b1;
        end else begin
          pend_o.status = ST_AT_END;
        end
      end
      CMD_CUR_FRONT: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else begin
          off_o               = '0;
          pend_o.bytes.cursor = bytes_i.front;
        end
      end
      CMD_CUR_BACK: begin
        if (empty) begin
          pend_o.status = ST_EMPTY;
        end else begin
          off_o               = cm1[IDX_W-1:0];
          pend_o.bytes.cursor = bytes_i.back;
        end
      end
      default: begin
      end
    endcase
    // reported count keeps the low five bits
    pend_o.item_count = 5'(cnt_o);
  end

endmodule

// ----- test/deque_with_cursor_core_test.sv -----
// deque_with_cursor_core_test: self-checking bench for the byte deque with cursor
// predicts every result from a shadow deque and compares it field by field
// depends on dwc_pkg and deque_with_cursor_core
`timescale 1ns / 1ps

module deque_with_cursor_core_test;
  import dwc_pkg::*;

  localparam int QDEPTH = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 307;
  // code with no action in the block
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cmd_valid = 1'b0;
  logic    cmd_ready;
  cmd_t    cmd_data = '0;
  logic    res_valid;
  logic    res_ready = 1'b0;
  result_t res_data;

  // shadow deque state
  logic [7:0] shadow_mem [QDEPTH];
  logic [3:0] shadow_head = '0;
  logic [4:0] shadow_count = '0;
  logic [3:0] shadow_cursor = '0;

  cmd_t    cmd_backlog [$];
  result_t due_results [$];
  int      unfinished = 0;
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  deque_with_cursor_core #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_data_i  (cmd_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ring slot of an offset from the front
  function automatic logic [3:0] slot_of(logic [4:0] offset);
    return shadow_head + offset[3:0];
  endfunction

  // stored byte at an offset, zero past the end
  function automatic logic [7:0] byte_at(logic [4:0] offset);
    if (shadow_count == 0 || offset >= shadow_count) return 8'h00;
    return shadow_mem[slot_of(offset)];
  endfunction

  // apply one command to the shadow deque and build its result
  function automatic result_t predict_result(cmd_t c);
    result_t r;
    logic    was_empty;
    r = '0;
    r.status = ST_DONE;
    was_empty = (shadow_count == 0);
    case (c.command)
      CMD_PUSH_BACK: begin
        if (shadow_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[slot_of(shadow_count)] = c.data_in;
          if (was_empty) shadow_cursor = '0;
          shadow_count = shadow_count + 5'd1;
        end
      end
      CMD_POP_FRONT: begin
        if (was_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = shadow_mem[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 5'd1;
          if (shadow_cursor > 0) shadow_cursor = shadow_cursor - 4'd1;
          if (shadow_count == 0) shadow_cursor = '0;
        end
      end
      CMD_POP_BACK: begin
        if (was_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = shadow_mem[slot_of(shadow_count - 5'd1)];
          shadow_count = shadow_count - 5'd1;
          if (shadow_count == 0) shadow_cursor = '0;
          else if ({1'b0, shadow_cursor} >= shadow_count)
            shadow_cursor = 4'(shadow_count - 5'd1);
        end
      end
      CMD_CUR_NEXT: begin
        if (was_empty) begin
          r.status = ST_EMPTY;
        end else if ({1'b0, shadow_cursor} + 5'd1 < shadow_count) begin
          shadow_cursor = shadow_cursor + 4'd1;
          r.data_out = byte_at({1'b0, shadow_cursor});
        end else begin
          r.status = ST_AT_END;
        end
      end
      CMD_CUR_PREV: begin
        if (was_empty) begin
          r.status = ST_EMPTY;
        end else if (shadow_cursor > 0) begin
          shadow_cursor = shadow_cursor - 4'd1;
          r.data_out = byte_at({1'b0, shadow_cursor});
        end else begin
          r.status = ST_AT_END;
        end
      end
      CMD_CUR_FRONT: begin
        if (was_empty) r.status = ST_EMPTY;
        else shadow_cursor = '0;
      end
      CMD_CUR_BACK: begin
        if (was_empty) r.status = ST_EMPTY;
        else shadow_cursor = 4'(shadow_count - 5'd1);
      end
      default: begin
      end
    endcase
    r.front_item = byte_at(5'd0);
    r.back_item = (shadow_count != 0) ? byte_at(shadow_count - 5'd1) : 8'h00;
    r.item_count = shadow_count;
    r.cursor_item = byte_at({1'b0, shadow_cursor});
    return r;
  endfunction

  // queue one command transaction for the driver
  task automatic queue_cmd(logic [2:0] code, logic [7:0] value);
    cmd_t c;
    c.command = code;
    c.data_in = value;
    cmd_backlog.push_back(c);
    unfinished++;
  endtask

  // random byte, leaning a little toward the extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random command, push share set by the current bias
  task automatic queue_random(int push_pct);
    logic [2:0] code;
    if ($urandom_range(0, 99) < push_pct) begin
      code = CMD_PUSH_BACK;
    end else begin
      case ($urandom_range(0, 12))
        0, 1, 2: code = CMD_POP_FRONT;
        3, 4, 5: code = CMD_POP_BACK;
        6, 7:    code = CMD_CUR_NEXT;
        8, 9:    code = CMD_CUR_PREV;
        10:      code = CMD_CUR_FRONT;
        11:      code = CMD_CUR_BACK;
        default: code = CMD_UNUSED;
      endcase
    end
    queue_cmd(code, rand_byte());
  endtask

  // wait until every queued transaction has its result back
  task automatic wait_drained();
    while (unfinished != 0) @(posedge clk_i);
  endtask

  // command driver and prediction on acceptance
  always @(posedge clk_i) begin : drive_cmd
    bit took;
    took = cmd_valid && cmd_ready;
    if (took) due_results.push_back(predict_result(cmd_data));
    if (!cmd_valid || took) begin
      if (rst_ni && cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_valid <= 1'b1;
        cmd_data <= cmd_backlog.pop_front();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : watch_result
    result_t want;
    if (res_valid && res_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual %h",
                 $time, res_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("data_out", want.data_out, res_data.data_out);
        check_field("status", 8'(want.status), 8'(res_data.status));
        check_field("front_item", want.front_item, res_data.front_item);
        check_field("back_item", want.back_item, res_data.back_item);
        check_field("item_count", 8'(want.item_count), 8'(res_data.item_count));
        check_field("cursor_item", want.cursor_item, res_data.cursor_item);
        unfinished--;
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("deque_with_cursor_core_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int seg_left;
    int push_bias;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every command but push back on an empty deque, unused code included
    queue_cmd(CMD_POP_FRONT, rand_byte());
    queue_cmd(CMD_POP_BACK, rand_byte());
    queue_cmd(CMD_CUR_NEXT, rand_byte());
    queue_cmd(CMD_CUR_PREV, rand_byte());
    queue_cmd(CMD_CUR_FRONT, rand_byte());
    queue_cmd(CMD_CUR_BACK, rand_byte());
    queue_cmd(CMD_UNUSED, rand_byte());
    // first push sets the cursor, data extremes
    queue_cmd(CMD_PUSH_BACK, 8'h00);
    queue_cmd(CMD_PUSH_BACK, 8'hff);
    queue_cmd(CMD_PUSH_BACK, 8'h5a);
    queue_cmd(CMD_PUSH_BACK, 8'ha5);
    // cursor walk with both ends hit
    queue_cmd(CMD_CUR_PREV, 8'h00);
    queue_cmd(CMD_CUR_NEXT, 8'hff);
    queue_cmd(CMD_CUR_NEXT, 8'h00);
    queue_cmd(CMD_CUR_NEXT, 8'hff);
    queue_cmd(CMD_CUR_NEXT, 8'h00);
    // pop back under the cursor, then pop front under the cursor
    queue_cmd(CMD_POP_BACK, 8'hff);
    queue_cmd(CMD_CUR_FRONT, 8'h00);
    queue_cmd(CMD_POP_FRONT, 8'hff);
    // pop front with the cursor elsewhere
    queue_cmd(CMD_CUR_BACK, 8'h00);
    queue_cmd(CMD_POP_FRONT, 8'hff);
    queue_cmd(CMD_UNUSED, 8'hff);
    // popping the last entry, then push into empty past a moved head
    queue_cmd(CMD_POP_FRONT, 8'h00);
    queue_cmd(CMD_PUSH_BACK, 8'h3c);
    wait_drained();

    // random phases: free flow, sender idle, receiver stall, both light
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      seg_left = 0;
      push_bias = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 60);
          case ($urandom_range(0, 2))
            0: push_bias = 15;
            1: push_bias = 50;
            default: push_bias = 80;
          endcase
        end
        queue_random(push_bias);
        seg_left--;
      end
      // long receiver hold-off while commands keep coming
      if (phase == 0) hold_req++;
      // sender pauses until every result is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("deque_with_cursor_core_test: done, clean");
    end else begin
      $display("deque_with_cursor_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- deque_with_cursor_core.f -----
hdl/dwc_pkg.sv
hdl/dwc_ram.sv
hdl/dwc_step.sv
hdl/deque_with_cursor_core.sv
test/deque_with_cursor_core_test.sv
